>>> rtl/obbsat_pkg.sv
package obbsat_pkg;

  // configuration register indexes
  localparam logic REG_CONTACT_MARGIN   = 1'b0;
  localparam logic REG_DEGENERATE_LIMIT = 1'b1;

  // operand source codes for the shared multiplier
  localparam logic [5:0] SRC_QA  = 6'd0;   // box a quaternion w,x,y,z
  localparam logic [5:0] SRC_QB  = 6'd4;   // box b quaternion w,x,y,z
  localparam logic [5:0] SRC_AXA = 6'd8;   // box a axes, row*3+col
  localparam logic [5:0] SRC_AXB = 6'd17;  // box b axes, row*3+col
  localparam logic [5:0] SRC_V   = 6'd26;  // candidate axis
  localparam logic [5:0] SRC_N   = 6'd29;  // normalized axis
  localparam logic [5:0] SRC_D   = 6'd32;  // center difference
  localparam logic [5:0] SRC_HA  = 6'd35;  // box a half extents
  localparam logic [5:0] SRC_HB  = 6'd38;  // box b half extents
  localparam logic [5:0] SRC_C   = 6'd41;  // rounded axis projection

  // quaternion index names
  localparam logic [1:0] QW = 2'd0;
  localparam logic [1:0] QX = 2'd1;
  localparam logic [1:0] QY = 2'd2;
  localparam logic [1:0] QZ = 2'd3;

  // rotation matrix terms: entry = one - or + 2*p1 +/- 2*p2
  localparam logic [1:0] QT_A1 [9] = '{QY, QX, QX, QX, QX, QY, QX, QY, QX};
  localparam logic [1:0] QT_B1 [9] = '{QY, QY, QZ, QY, QX, QZ, QZ, QZ, QX};
  localparam logic       QT_N1 [9] = '{1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1};
  localparam logic [1:0] QT_A2 [9] = '{QZ, QW, QW, QW, QZ, QW, QW, QW, QY};
  localparam logic [1:0] QT_B2 [9] = '{QZ, QZ, QY, QZ, QZ, QX, QY, QX, QY};
  localparam logic       QT_N2 [9] = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1};
  localparam logic       QT_ONE[9] = '{1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1};

  // datapath actions besides the multiply-accumulate
  typedef enum logic [3:0] {
    FIN_NONE,
    FIN_AX,
    FIN_VFACE,
    FIN_VCROSS,
    FIN_SQ,
    FIN_SQRT_STEP,
    FIN_DIV_INIT,
    FIN_DIV_STEP,
    FIN_DIV_DONE,
    FIN_C,
    FIN_CMP
  } fin_e;

  typedef struct packed {
    logic       mac;
    logic [5:0] a_sel;
    logic [5:0] b_sel;
    logic       neg;
    logic       dbl;
    logic       clr;
    logic       one;
    logic       rsum;
    fin_e       fin;
    logic [4:0] idx;
  } cmd_t;

  typedef struct packed {
    logic skip;
  } stat_t;

endpackage

>>> rtl/obb_overlap_separating_axis_top.sv
// Oriented box penetration test over fifteen separating axes.
// Input stream: tuser carries is_second. An item with is_second low stores its
// box as box a and gives no result. An item with is_second high
// tests its box against the stored box a and gives one result item whose
// tdata bit 0 is overlap (1 when the boxes penetrate).
// A test first builds both rotation matrices, then for each face axis and
// each cross axis forms the candidate, takes its squared length, runs 32
// square root steps and three divides, and does the multiply accumulate
// steps of the radii and the projection; a degenerate axis goes to the next
// axis after its squared length check. All products go through one shared
// multiplier, one at a time, so one test item is in flight at once.
// The configuration channel writes contact_margin (index 0) and
// degenerate_limit (index 1); it is always ready. The user is to write it
// only while idle; the block itself does not enforce this.
// Reset clears box a to zero center, zero extents and zero quaternion, and
// sets contact_margin to 128 and degenerate_limit to 1.
// While the result is not taken the block holds it and accepts no new item.
module obb_overlap_separating_axis_top #(
  parameter int COORD_BITS  = 32,
  parameter int EXTENT_BITS = 24
) (
  input  logic clk_i,
  input  logic rst_ni,
  // center_x, center_y, center_z, half_x, half_y, half_z,
  // quat_w, quat_x, quat_y, quat_z
  input  logic [((3*COORD_BITS+3*EXTENT_BITS+64+7)/8)*8-1:0] s_axis_tdata,
  // is_second
  input  logic        s_axis_tuser,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // overlap
  output logic [7:0]  m_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_data_i
);
  import obbsat_pkg::*;

  localparam int OFS_H = 3 * COORD_BITS;
  localparam int OFS_Q = 3 * COORD_BITS + 3 * EXTENT_BITS;

  logic [15:0] contact_margin_q, degenerate_limit_q;
  logic        in_acc, overlap;
  cmd_t        cmd;
  stat_t       stat;

  logic [COORD_BITS-1:0]  center [3];
  logic [EXTENT_BITS-1:0] half [3];
  logic [15:0]            quat [4];

  // unpack the input item
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      center[i] = s_axis_tdata[i*COORD_BITS +: COORD_BITS];
      half[i]   = s_axis_tdata[OFS_H + i*EXTENT_BITS +: EXTENT_BITS];
    end
    for (int i = 0; i < 4; i++) quat[i] = s_axis_tdata[OFS_Q + i*16 +: 16];
  end

  assign in_acc       = s_axis_tvalid & s_axis_tready;
  assign cfg_ready_o  = 1'b1;
  assign m_axis_tdata = {7'b0, overlap};

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      contact_margin_q   <= 16'd128;
      degenerate_limit_q <= 16'd1;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_CONTACT_MARGIN:   contact_margin_q   <= cfg_data_i;
        REG_DEGENERATE_LIMIT: degenerate_limit_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  obbsat_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (in_acc & s_axis_tuser),
    .stat_i      (stat),
    .out_ready_i (m_axis_tready),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .cmd_o       (cmd)
  );

  obbsat_dp #(
    .COORD_BITS  (COORD_BITS),
    .EXTENT_BITS (EXTENT_BITS)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .load_i             (in_acc),
    .is_second_i        (s_axis_tuser),
    .center_i           (center),
    .half_i             (half),
    .quat_i             (quat),
    .contact_margin_i   (contact_margin_q),
    .degenerate_limit_i (degenerate_limit_q),
    .cmd_i              (cmd),
    .stat_o             (stat),
    .overlap_o          (overlap)
  );

endmodule

>>> rtl/obbsat_dp.sv
module obbsat_dp #(
  parameter int COORD_BITS  = 32,
  parameter int EXTENT_BITS = 24
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   load_i,
  input  logic                   is_second_i,
  input  logic [COORD_BITS-1:0]  center_i [3],
  input  logic [EXTENT_BITS-1:0] half_i [3],
  input  logic [15:0]            quat_i [4],
  input  logic [15:0]            contact_margin_i,
  input  logic [15:0]            degenerate_limit_i,
  input  obbsat_pkg::cmd_t       cmd_i,
  output obbsat_pkg::stat_t      stat_o,
  output logic                   overlap_o
);
  import obbsat_pkg::*;

  localparam int MX    = (COORD_BITS > EXTENT_BITS) ? COORD_BITS : EXTENT_BITS;
  localparam int NB    = 20;
  localparam int OPW   = (MX + 1 > NB) ? MX + 1 : NB;
  localparam int PW    = OPW + NB;
  localparam int ACC_W = PW + 2;

  // held box a and the current box b
  logic signed [COORD_BITS-1:0] ca_q [3];
  logic        [EXTENT_BITS-1:0] ha_q [3];
  logic        [EXTENT_BITS-1:0] hb_q [3];
  logic signed [15:0]           qa_q [4];
  logic signed [15:0]           qb_q [4];
  logic signed [COORD_BITS:0]   d_q [3];

  // working registers
  logic signed [15:0]      ax_q [18];
  logic signed [18:0]      v_q [3];
  logic signed [16:0]      n_q [3];
  logic        [15:0]      c_q;
  logic signed [ACC_W-1:0] acc_q, rsum_q;
  logic signed [PW-1:0]    prod_q;
  logic                    m_vld_q, m_neg_q, m_dbl_q, m_init_q, m_one_q, m_rs_q;
  logic                    sep_q;

  // square root and divider
  logic [63:0] rx_q;
  logic [35:0] rrem_q;
  logic [31:0] rroot_q;
  logic [15:0] dn_q;
  logic [32:0] drem_q;
  logic [15:0] dq_q;
  logic        dneg_q;

  logic signed [OPW-1:0] src [64];
  logic signed [OPW-1:0] opa;
  logic signed [NB-1:0]  opb;
  logic signed [PW-1:0]  prod_d;

  function automatic logic signed [ACC_W-1:0] rnd14(input logic signed [ACC_W-1:0] x);
    logic [ACC_W-1:0] mag;
    logic [ACC_W-1:0] q;
    mag = x[ACC_W-1] ? unsigned'(-x) : unsigned'(x);
    q   = (mag + ACC_W'(8192)) >> 14;
    return x[ACC_W-1] ? -signed'(q) : signed'(q);
  endfunction

  // operand selection
  always_comb begin
    for (int i = 0; i < 64; i++) src[i] = '0;
    for (int i = 0; i < 4; i++) begin
      src[SRC_QA + i] = OPW'(qa_q[i]);
      src[SRC_QB + i] = OPW'(qb_q[i]);
    end
    for (int i = 0; i < 9; i++) begin
      src[SRC_AXA + i] = OPW'(ax_q[i]);
      src[SRC_AXB + i] = OPW'(ax_q[9 + i]);
    end
    for (int i = 0; i < 3; i++) begin
      src[SRC_V + i]  = OPW'(v_q[i]);
      src[SRC_N + i]  = OPW'(n_q[i]);
      src[SRC_D + i]  = OPW'(d_q[i]);
      src[SRC_HA + i] = signed'(OPW'(ha_q[i]));
      src[SRC_HB + i] = signed'(OPW'(hb_q[i]));
    end
    src[SRC_C] = signed'(OPW'(c_q));
  end

  assign opa    = src[cmd_i.a_sel];
  assign opb    = src[cmd_i.b_sel][NB-1:0];
  assign prod_d = opa * opb;

  // combinational helpers for finishing actions
  logic signed [ACC_W-1:0] acc_rnd, acc_abs, lim, term;
  logic [35:0] sq_rem;
  logic [33:0] sq_try;
  logic [33:0] dv_rem;
  logic [17:0] vmag;
  logic [45:0] dnum;
  logic [2:0][4:0] face_idx;

  assign acc_rnd = rnd14(acc_q);
  assign acc_abs = acc_q[ACC_W-1] ? -acc_q : acc_q;
  assign lim     = rsum_q - (signed'(ACC_W'(contact_margin_i)) <<< 14);
  assign sq_rem  = {rrem_q[33:0], rx_q[63:62]};
  assign sq_try  = {rroot_q, 2'b01};
  assign dv_rem  = {drem_q, dn_q[15]};
  assign vmag    = v_q[cmd_i.idx[1:0]][18] ? 18'(-v_q[cmd_i.idx[1:0]])
                                           : 18'(v_q[cmd_i.idx[1:0]]);
  assign dnum    = {1'b0, vmag, 27'b0} + 46'(rroot_q >> 1);
  assign term    = m_dbl_q ? (ACC_W'(prod_q) <<< 1) : ACC_W'(prod_q);

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      face_idx[c] = 5'({cmd_i.idx[2:0], 1'b0}) + 5'(cmd_i.idx[2:0]) + 5'(c);
    end
  end

  // degenerate axis check on the squared length
  assign stat_o.skip = (acc_q == '0) || (unsigned'(acc_q) < ACC_W'(degenerate_limit_i));
  assign overlap_o   = ~sep_q;

  // held box a, cleared by reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        ca_q[i] <= '0;
        ha_q[i] <= '0;
      end
      for (int i = 0; i < 4; i++) qa_q[i] <= '0;
    end else if (load_i && !is_second_i) begin
      for (int i = 0; i < 3; i++) begin
        ca_q[i] <= signed'(center_i[i]);
        ha_q[i] <= half_i[i];
      end
      for (int i = 0; i < 4; i++) qa_q[i] <= signed'(quat_i[i]);
    end
  end

  // multiplier pipeline control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_vld_q <= 1'b0;
    end else begin
      m_vld_q <= cmd_i.mac;
    end
  end

  // box b capture, multiply-accumulate and finishing actions
  always_ff @(posedge clk_i) begin
    prod_q   <= prod_d;
    m_neg_q  <= cmd_i.neg;
    m_dbl_q  <= cmd_i.dbl;
    m_init_q <= cmd_i.clr | cmd_i.one;
    m_one_q  <= cmd_i.one;
    m_rs_q   <= cmd_i.rsum;

    if (load_i) begin
      sep_q <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        hb_q[i] <= half_i[i];
        d_q[i]  <= (COORD_BITS+1)'(signed'(center_i[i])) - (COORD_BITS+1)'(ca_q[i]);
      end
      for (int i = 0; i < 4; i++) qb_q[i] <= signed'(quat_i[i]);
    end

    // accumulate stage
    if (m_vld_q) begin
      if (m_rs_q) begin
        rsum_q <= (m_init_q ? '0 : rsum_q) + (m_neg_q ? -term : term);
      end else begin
        acc_q <= (m_init_q ? (m_one_q ? ACC_W'(1 << 28) : '0) : acc_q)
                 + (m_neg_q ? -term : term);
      end
    end

    case (cmd_i.fin)
      FIN_AX: begin
        if (acc_rnd > ACC_W'(32767))       ax_q[cmd_i.idx] <= 16'sd32767;
        else if (acc_rnd < -ACC_W'(32767)) ax_q[cmd_i.idx] <= -16'sd32767;
        else                               ax_q[cmd_i.idx] <= acc_rnd[15:0];
      end
      FIN_VFACE: begin
        for (int c = 0; c < 3; c++) v_q[c] <= 19'(ax_q[face_idx[c]]);
      end
      FIN_VCROSS: v_q[cmd_i.idx[1:0]] <= acc_rnd[18:0];
      FIN_SQ: begin
        rx_q    <= {acc_q[37:0], 26'b0};
        rrem_q  <= '0;
        rroot_q <= '0;
      end
      FIN_SQRT_STEP: begin
        rx_q <= {rx_q[61:0], 2'b00};
        if (sq_rem >= 36'(sq_try)) begin
          rrem_q  <= sq_rem - 36'(sq_try);
          rroot_q <= {rroot_q[30:0], 1'b1};
        end else begin
          rrem_q  <= sq_rem;
          rroot_q <= {rroot_q[30:0], 1'b0};
        end
      end
      FIN_DIV_INIT: begin
        drem_q <= 33'(dnum[45:16]);
        dn_q   <= dnum[15:0];
        dq_q   <= '0;
        dneg_q <= v_q[cmd_i.idx[1:0]][18];
      end
      FIN_DIV_STEP: begin
        dn_q <= {dn_q[14:0], 1'b0};
        if (dv_rem >= 34'(rroot_q)) begin
          drem_q <= 33'(dv_rem - 34'(rroot_q));
          dq_q   <= {dq_q[14:0], 1'b1};
        end else begin
          drem_q <= dv_rem[32:0];
          dq_q   <= {dq_q[14:0], 1'b0};
        end
      end
      FIN_DIV_DONE: begin
        n_q[cmd_i.idx[1:0]] <= dneg_q ? -signed'(17'(dq_q)) : signed'(17'(dq_q));
      end
      FIN_C: c_q <= 16'(rnd14(acc_abs));
      FIN_CMP: begin
        if (acc_abs >= lim) sep_q <= 1'b1;
      end
      default: begin
      end
    endcase
  end

endmodule

>>> rtl/obbsat_ctrl.sv
module obbsat_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  obbsat_pkg::stat_t stat_i,
  input  logic              out_ready_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  output obbsat_pkg::cmd_t  cmd_o
);
  import obbsat_pkg::*;

  typedef enum logic [9:0] {
    ST_IDLE = 10'b0000000001,
    ST_AXES = 10'b0000000010,
    ST_VEC  = 10'b0000000100,
    ST_SQ   = 10'b0000001000,
    ST_ROOT = 10'b0000010000,
    ST_DIV  = 10'b0000100000,
    ST_RAD  = 10'b0001000000,
    ST_PROJ = 10'b0010000000,
    ST_NEXT = 10'b0100000000,
    ST_OUT  = 10'b1000000000
  } state_e;

  state_e     state_q, state_d;
  logic [6:0] cnt_q, cnt_d;
  logic [2:0] grp_q, grp_d;
  logic [3:0] axis_q, axis_d;

  // derived indexes
  logic [4:0] comp;
  logic       boxb;
  logic [3:0] ent;
  logic [5:0] qbase;
  logic [3:0] kx;
  logic [1:0] ci, cj, cc, cu, cw, rk;
  logic       rb;

  always_comb begin
    comp  = cnt_q[6:2];
    boxb  = (comp >= 5'd9);
    ent   = boxb ? 4'(comp - 5'd9) : comp[3:0];
    qbase = boxb ? SRC_QB : SRC_QA;
    kx    = axis_q - 4'd6;
    ci    = (kx >= 4'd6) ? 2'd2 : (kx >= 4'd3) ? 2'd1 : 2'd0;
    cj    = 2'(kx - ((ci == 2'd2) ? 4'd6 : (ci == 2'd1) ? 4'd3 : 4'd0));
    cc    = cnt_q[3:2];
    cu    = (cc == 2'd2) ? 2'd0 : cc + 2'd1;
    cw    = (cc == 2'd0) ? 2'd2 : cc - 2'd1;
    rb    = (grp_q >= 3'd3);
    rk    = rb ? 2'(grp_q - 3'd3) : grp_q[1:0];
  end

  // sequencing
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    grp_d       = grp_q;
    axis_d      = axis_q;
    cmd_o       = '0;
    cmd_o.fin   = FIN_NONE;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (start_i) begin
          state_d = ST_AXES;
          cnt_d   = '0;
        end
      end
      // rotation matrices of both boxes, two products per entry
      ST_AXES: begin
        case (cnt_q[1:0])
          2'd0: begin
            cmd_o.mac   = 1'b1;
            cmd_o.a_sel = qbase + 6'(QT_A1[ent]);
            cmd_o.b_sel = qbase + 6'(QT_B1[ent]);
            cmd_o.neg   = QT_N1[ent];
            cmd_o.dbl   = 1'b1;
            cmd_o.clr   = ~QT_ONE[ent];
            cmd_o.one   = QT_ONE[ent];
          end
          2'd1: begin
            cmd_o.mac   = 1'b1;
            cmd_o.a_sel = qbase + 6'(QT_A2[ent]);
            cmd_o.b_sel = qbase + 6'(QT_B2[ent]);
            cmd_o.neg   = QT_N2[ent];
            cmd_o.dbl   = 1'b1;
          end
          2'd3: begin
            cmd_o.fin = FIN_AX;
            cmd_o.idx = comp;
          end
          default: begin
          end
        endcase
        if (cnt_q == 7'd71) begin
          state_d = ST_VEC;
          cnt_d   = '0;
          axis_d  = '0;
        end else begin
          cnt_d = cnt_q + 7'd1;
        end
      end
      // candidate axis: a face axis or a cross product
      ST_VEC: begin
        if (axis_q < 4'd6) begin
          cmd_o.fin = FIN_VFACE;
          cmd_o.idx = 5'(axis_q);
          state_d   = ST_SQ;
          cnt_d     = '0;
        end else begin
          case (cnt_q[1:0])
            2'd0: begin
              cmd_o.mac   = 1'b1;
              cmd_o.a_sel = SRC_AXA + 6'({ci, 1'b0}) + 6'(ci) + 6'(cu);
              cmd_o.b_sel = SRC_AXB + 6'({cj, 1'b0}) + 6'(cj) + 6'(cw);
              cmd_o.clr   = 1'b1;
            end
            2'd1: begin
              cmd_o.mac   = 1'b1;
              cmd_o.a_sel = SRC_AXA + 6'({ci, 1'b0}) + 6'(ci) + 6'(cw);
              cmd_o.b_sel = SRC_AXB + 6'({cj, 1'b0}) + 6'(cj) + 6'(cu);
              cmd_o.neg   = 1'b1;
            end
            2'd3: begin
              cmd_o.fin = FIN_VCROSS;
              cmd_o.idx = 5'(cc);
            end
            default: begin
            end
          endcase
          if (cnt_q == 7'd11) begin
            state_d = ST_SQ;
            cnt_d   = '0;
          end else begin
            cnt_d = cnt_q + 7'd1;
          end
        end
      end
      // squared length and degenerate check
      ST_SQ: begin
        if (cnt_q < 7'd3) begin
          cmd_o.mac   = 1'b1;
          cmd_o.a_sel = SRC_V + 6'(cnt_q);
          cmd_o.b_sel = SRC_V + 6'(cnt_q);
          cmd_o.clr   = (cnt_q == 7'd0);
        end
        if (cnt_q == 7'd4) begin
          cmd_o.fin = FIN_SQ;
          state_d   = stat_i.skip ? ST_NEXT : ST_ROOT;
          cnt_d     = '0;
        end else begin
          cnt_d = cnt_q + 7'd1;
        end
      end
      ST_ROOT: begin
        cmd_o.fin = FIN_SQRT_STEP;
        if (cnt_q == 7'd31) begin
          state_d = ST_DIV;
          cnt_d   = '0;
          grp_d   = '0;
        end else begin
          cnt_d = cnt_q + 7'd1;
        end
      end
      // one divide per component of the normalized axis
      ST_DIV: begin
        cmd_o.idx = 5'(grp_q);
        if (cnt_q == 7'd0)       cmd_o.fin = FIN_DIV_INIT;
        else if (cnt_q == 7'd17) cmd_o.fin = FIN_DIV_DONE;
        else                     cmd_o.fin = FIN_DIV_STEP;
        if (cnt_q == 7'd17) begin
          cnt_d = '0;
          if (grp_q == 3'd2) begin
            state_d = ST_RAD;
            grp_d   = '0;
          end else begin
            grp_d = grp_q + 3'd1;
          end
        end else begin
          cnt_d = cnt_q + 7'd1;
        end
      end
      // projected radius, one box axis per group
      ST_RAD: begin
        if (cnt_q < 7'd3) begin
          cmd_o.mac   = 1'b1;
          cmd_o.a_sel = SRC_N + 6'(cnt_q);
          cmd_o.b_sel = (rb ? SRC_AXB : SRC_AXA) + 6'({rk, 1'b0}) + 6'(rk) + 6'(cnt_q);
          cmd_o.clr   = (cnt_q == 7'd0);
        end else if (cnt_q == 7'd4) begin
          cmd_o.fin = FIN_C;
        end else if (cnt_q == 7'd5) begin
          cmd_o.mac   = 1'b1;
          cmd_o.a_sel = (rb ? SRC_HB : SRC_HA) + 6'(rk);
          cmd_o.b_sel = SRC_C;
          cmd_o.rsum  = 1'b1;
          cmd_o.clr   = (grp_q == 3'd0);
        end
        if (cnt_q == 7'd5) begin
          cnt_d = '0;
          if (grp_q == 3'd5) begin
            state_d = ST_PROJ;
          end else begin
            grp_d = grp_q + 3'd1;
          end
        end else begin
          cnt_d = cnt_q + 7'd1;
        end
      end
      // projected center distance and separation test
      ST_PROJ: begin
        if (cnt_q < 7'd3) begin
          cmd_o.mac   = 1'b1;
          cmd_o.a_sel = SRC_D + 6'(cnt_q);
          cmd_o.b_sel = SRC_N + 6'(cnt_q);
          cmd_o.clr   = (cnt_q == 7'd0);
        end
        if (cnt_q == 7'd4) begin
          cmd_o.fin = FIN_CMP;
          state_d   = ST_NEXT;
          cnt_d     = '0;
        end else begin
          cnt_d = cnt_q + 7'd1;
        end
      end
      ST_NEXT: begin
        cnt_d = '0;
        if (axis_q == 4'd14) begin
          state_d = ST_OUT;
        end else begin
          axis_d  = axis_q + 4'd1;
          state_d = ST_VEC;
        end
      end
      ST_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // state and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      grp_q   <= '0;
      axis_q  <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      grp_q   <= grp_d;
      axis_q  <= axis_d;
    end
  end

endmodule
